// ===== rtl/core/tmmt_pkg.sv =====
`default_nettype none

package tmmt_pkg;

    localparam int NODES        = 4096;
    localparam int VALUES       = 4096;
    localparam int BUCKET_WIDTH = 64;   // power of two
    localparam int NUM_BUCKETS  = 64;

    localparam int NODE_W   = 12;
    localparam int WEIGHT_W = 18;
    localparam int MEX_W    = 13;
    localparam int CNT_W    = 13;
    localparam int COUNT_MAX = (2 ** CNT_W) - 1;

    localparam int MAIN_DEPTH = (NODES > VALUES) ? NODES : VALUES;
    localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
    localparam int BW_W       = $clog2(BUCKET_WIDTH);
    localparam int BKT_W      = $clog2(NUM_BUCKETS);
    localparam int BPTR_W     = $clog2(NUM_BUCKETS + 1);
    localparam int VPTR_W     = $clog2(BUCKET_WIDTH + 1);
    localparam int DIST_W     = $clog2(BUCKET_WIDTH + 1);
    localparam int COVERED    = NUM_BUCKETS * BUCKET_WIDTH;
    localparam int SCAN_W     = $clog2(COVERED + 1);

    // one word of the shared store: membership of node i and count of weight i
    typedef struct packed {
        logic             member;
        logic [CNT_W-1:0] count;
    } main_word_t;

    localparam int MAIN_WW = $bits(main_word_t);

endpackage

`default_nettype wire

// ===== rtl/core/tmmt_ram.sv =====
`default_nettype none

module tmmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/toggle_multiset_mex_tracker.sv =====
`default_nettype none

// Multiset of node weights under membership toggles, reporting the smallest
// absent weight (mex) after every word. After reset the block sweeps its
// stores once, over MAIN_DEPTH addresses, with item_stall high. An item then
// reads, toggles and writes back the node word, reads the weight word and
// the bucket count and writes back their updated counts; then it makes one
// bucket-count read per cycle to find the first bucket with a gap and one
// value-count read per cycle inside it. With every bucket full the value scan
// is skipped; a word with an out-of-range weight skips the weight read and
// write-back. Each scan is bound by the single read port of its memory. The
// result waits in an output register, so a new word can be taken while the
// last result is still held; a result only waits longer when the one before
// it is still stalled at the output.
module toggle_multiset_mex_tracker
    import tmmt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic [NODE_W-1:0]   node_id,
    input  wire logic [WEIGHT_W-1:0] node_weight,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic      [MEX_W-1:0]    mex_value,
    output logic                     ignored,
    output logic                     now_member
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_NODE  = 4'd2;
    localparam logic [3:0] S_WRD   = 4'd3;
    localparam logic [3:0] S_WT    = 4'd4;
    localparam logic [3:0] S_SCANB = 4'd5;
    localparam logic [3:0] S_SCANV = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]         state_reg, state_next;
    logic [MAIN_AW-1:0] clr_reg, clr_next;
    logic [MAIN_AW-1:0] node_reg, node_next;
    logic [MAIN_AW-1:0] w_reg, w_next;
    logic               wt_ok_reg, wt_ok_next;
    logic               ign_reg, ign_next;
    logic               member_reg, member_next;
    logic               old_member_reg, old_member_next;
    logic [BPTR_W-1:0]  bptr_reg, bptr_next;
    logic [BKT_W-1:0]   cur_reg, cur_next;
    logic               pend_reg, pend_next;
    logic [VPTR_W-1:0]  vptr_reg, vptr_next;
    logic [SCAN_W-1:0]  jp_reg, jp_next;
    logic [MEX_W-1:0]   mex_reg, mex_next;
    logic               out_valid_reg, out_valid_next;
    logic [MEX_W-1:0]   mex_out_reg, mex_out_next;
    logic               ign_out_reg, ign_out_next;
    logic               member_out_reg, member_out_next;

    logic               m_we;
    logic [MAIN_AW-1:0] m_waddr, m_raddr;
    main_word_t         m_wdata, m_rdata;
    logic               b_we;
    logic [BKT_W-1:0]   b_waddr, b_raddr;
    logic [DIST_W-1:0]  b_wdata, b_rdata;

    logic               item_fire;
    logic               node_ok;
    logic [BKT_W-1:0]   w_bucket;
    logic               w_covered;
    logic [SCAN_W-1:0]  scan_j;

    tmmt_ram #(
        .WIDTH (MAIN_WW),
        .DEPTH (MAIN_DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    tmmt_ram #(
        .WIDTH (DIST_W),
        .DEPTH (NUM_BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign item_stall = (state_reg != S_IDLE);
    assign item_fire  = item_valid && !item_stall;
    assign node_ok    = (32'(node_id) < NODES);
    assign w_bucket   = BKT_W'(w_reg >> BW_W);
    assign w_covered  = (32'(w_reg) < COVERED);
    assign scan_j     = (SCAN_W'(cur_reg) << BW_W) + SCAN_W'(vptr_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        node_next       = node_reg;
        w_next          = w_reg;
        wt_ok_next      = wt_ok_reg;
        ign_next        = ign_reg;
        member_next     = member_reg;
        old_member_next = old_member_reg;
        bptr_next       = bptr_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        vptr_next       = vptr_reg;
        jp_next         = jp_reg;
        mex_next        = mex_reg;
        out_valid_next  = out_valid_reg && result_stall;
        mex_out_next    = mex_out_reg;
        ign_out_next    = ign_out_reg;
        member_out_next = member_out_reg;

        m_we    = 1'b0;
        m_waddr = node_reg;
        m_wdata = m_rdata;
        m_raddr = node_reg;
        b_we    = 1'b0;
        b_waddr = w_bucket;
        b_wdata = b_rdata;
        b_raddr = w_bucket;

        unique case (state_reg)
            S_CLEAR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = '0;
                b_we    = (32'(clr_reg) < NUM_BUCKETS);
                b_waddr = clr_reg[BKT_W-1:0];
                b_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MAIN_AW'(MAIN_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (item_fire)
                begin
                    node_next  = MAIN_AW'(node_id);
                    w_next     = MAIN_AW'(node_weight);
                    wt_ok_next = (32'(node_weight) < VALUES);
                    m_raddr    = MAIN_AW'(node_id);
                    if (node_ok)
                    begin
                        state_next = S_NODE;
                    end
                    else
                    begin
                        ign_next    = 1'b1;
                        member_next = 1'b0;
                        bptr_next   = '0;
                        pend_next   = 1'b0;
                        state_next  = S_SCANB;
                    end
                end
            end

            S_NODE:
            begin
                if (!wt_ok_reg)
                begin
                    ign_next    = 1'b1;
                    member_next = m_rdata.member;
                    bptr_next   = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SCANB;
                end
                else
                begin
                    // toggle membership, keep the count held in the same word
                    m_we            = 1'b1;
                    m_waddr         = node_reg;
                    m_wdata.member  = !m_rdata.member;
                    m_wdata.count   = m_rdata.count;
                    ign_next        = 1'b0;
                    old_member_next = m_rdata.member;
                    member_next     = !m_rdata.member;
                    state_next      = S_WRD;
                end
            end

            S_WRD:
            begin
                m_raddr    = w_reg;
                b_raddr    = w_bucket;
                state_next = S_WT;
            end

            S_WT:
            begin
                m_waddr        = w_reg;
                m_wdata.member = m_rdata.member;
                m_wdata.count  = m_rdata.count;
                b_waddr        = w_bucket;
                if (old_member_reg)
                begin
                    if (m_rdata.count != '0)
                    begin
                        m_we          = 1'b1;
                        m_wdata.count = m_rdata.count - 1'b1;
                        if (m_rdata.count == CNT_W'(1) && w_covered && b_rdata != '0)
                        begin
                            b_we    = 1'b1;
                            b_wdata = b_rdata - 1'b1;
                        end
                    end
                end
                else
                begin
                    if (m_rdata.count != CNT_W'(COUNT_MAX))
                    begin
                        m_we          = 1'b1;
                        m_wdata.count = m_rdata.count + 1'b1;
                        if (m_rdata.count == '0 && w_covered)
                        begin
                            b_we    = 1'b1;
                            b_wdata = b_rdata + 1'b1;
                        end
                    end
                end
                bptr_next  = '0;
                pend_next  = 1'b0;
                state_next = S_SCANB;
            end

            S_SCANB:
            begin
                // b_rdata belongs to bucket cur_reg when pend_reg is set
                if (pend_reg && (b_rdata < DIST_W'(BUCKET_WIDTH)))
                begin
                    vptr_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCANV;
                end
                else if (32'(bptr_reg) < NUM_BUCKETS)
                begin
                    b_raddr   = bptr_reg[BKT_W-1:0];
                    cur_next  = bptr_reg[BKT_W-1:0];
                    pend_next = 1'b1;
                    bptr_next = bptr_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mex_next   = MEX_W'(VALUES);
                        state_next = S_DONE;
                    end
                end
            end

            S_SCANV:
            begin
                // m_rdata belongs to value jp_reg when pend_reg is set
                if (pend_reg && m_rdata.count == '0)
                begin
                    mex_next   = MEX_W'(jp_reg);
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if ((32'(vptr_reg) < BUCKET_WIDTH) && (32'(scan_j) < VALUES))
                begin
                    m_raddr   = MAIN_AW'(scan_j);
                    jp_next   = scan_j;
                    pend_next = 1'b1;
                    vptr_next = vptr_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // no gap here after all: resume with the next bucket
                        bptr_next  = BPTR_W'(cur_reg) + 1'b1;
                        state_next = S_SCANB;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    mex_out_next    = mex_reg;
                    ign_out_next    = ign_reg;
                    member_out_next = member_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            bptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            bptr_reg      <= bptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        w_reg          <= w_next;
        wt_ok_reg      <= wt_ok_next;
        ign_reg        <= ign_next;
        member_reg     <= member_next;
        old_member_reg <= old_member_next;
        cur_reg        <= cur_next;
        vptr_reg       <= vptr_next;
        jp_reg         <= jp_next;
        mex_reg        <= mex_next;
        mex_out_reg    <= mex_out_next;
        ign_out_reg    <= ign_out_next;
        member_out_reg <= member_out_next;
    end

    assign result_valid = out_valid_reg;
    assign mex_value    = mex_out_reg;
    assign ignored      = ign_out_reg;
    assign now_member   = member_out_reg;

endmodule

`default_nettype wire

// ===== verif/toggle_multiset_mex_tracker_test.sv =====
module toggle_multiset_mex_tracker_test
    import tmmt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES   = 2_000_000;
    localparam int RANDOM_PER_MIX = 350;
    localparam int SETTLE_CYCLES  = 200;

    typedef struct {
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;
    } toggle_word_t;

    typedef struct {
        logic [MEX_W-1:0] mex;
        logic             ign;
        logic             member;
    } mex_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [NODE_W-1:0]   node_id = '0;
    logic [WEIGHT_W-1:0] node_weight = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [MEX_W-1:0]    mex_value;
    logic                ignored;
    logic                now_member;

    toggle_word_t pending_words[$];
    mex_report_t  expected_reports[$];

    // multiset as the block should hold it, advanced on each accepted word
    bit                 track_member[NODES];
    bit [CNT_W-1:0]     track_count[VALUES];
    int unsigned        track_distinct[NUM_BUCKETS];

    // membership as the stimulus will leave it once every queued word is in
    bit                  planned_member[NODES];
    int unsigned         planned_weight[NODES];
    int unsigned         member_pool[$];
    int unsigned         frontier = 0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;

    toggle_multiset_mex_tracker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .node_id      (node_id),
        .node_weight  (node_weight),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .mex_value    (mex_value),
        .ignored      (ignored),
        .now_member   (now_member)
    );

    always #2 clk = ~clk;

    function automatic int unsigned search_mex();
        int unsigned b;
        int unsigned j;
        for (b = 0; b < NUM_BUCKETS; b++)
        begin
            if (track_distinct[b] < BUCKET_WIDTH)
            begin
                for (j = b * BUCKET_WIDTH; j < (b + 1) * BUCKET_WIDTH && j < VALUES; j++)
                begin
                    if (track_count[j] == 0)
                        return j;
                end
            end
        end
        return VALUES;
    endfunction

    function automatic mex_report_t predict_mex_report(toggle_word_t w);
        mex_report_t rep;
        int unsigned wt;
        int unsigned bkt;
        rep.ign = 1'b0;
        rep.member = 1'b0;
        if (int'(w.node) >= NODES)
        begin
            rep.ign = 1'b1;
        end
        else if (int'(w.weight) >= VALUES)
        begin
            rep.ign = 1'b1;
            rep.member = track_member[w.node];
        end
        else
        begin
            wt = 32'(w.weight);
            bkt = wt / BUCKET_WIDTH;
            if (track_member[w.node])
            begin
                // leaving with a weight already at zero changes no count
                if (track_count[wt] != 0)
                begin
                    if (track_count[wt] == 1 && bkt < NUM_BUCKETS && track_distinct[bkt] != 0)
                        track_distinct[bkt]--;
                    track_count[wt]--;
                end
                track_member[w.node] = 1'b0;
            end
            else
            begin
                // hold the count once saturated
                if (track_count[wt] < COUNT_MAX)
                begin
                    if (track_count[wt] == 0 && bkt < NUM_BUCKETS)
                        track_distinct[bkt]++;
                    track_count[wt]++;
                end
                track_member[w.node] = 1'b1;
            end
            rep.member = track_member[w.node];
        end
        rep.mex = MEX_W'(search_mex());
        return rep;
    endfunction

    function automatic void plan_word(int unsigned node, int unsigned weight);
        toggle_word_t w;
        w.node = NODE_W'(node);
        w.weight = WEIGHT_W'(weight);
        pending_words = {pending_words, w};
        if (weight < VALUES)
        begin
            planned_member[node] = !planned_member[node];
            if (planned_member[node])
                planned_weight[node] = weight;
        end
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        toggle_word_t w;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            node_id <= '0;
            node_weight <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                w.node = node_id;
                w.weight = node_weight;
                expected_reports = {expected_reports, predict_mex_report(w)};
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = pending_words.pop_front();
                    item_valid <= 1'b1;
                    node_id <= w.node;
                    node_weight <= w.weight;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        mex_report_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result word with nothing pending: mex %0d ign %0b mem %0b",
                                 mex_value, ignored, now_member);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (mex_value !== want.mex || ignored !== want.ign
                        || now_member !== want.member)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected mex %0d ign %0b mem %0b, %s %0d %0b %0b",
                                     want.mex, want.ign, want.member, "got",
                                     mex_value, ignored, now_member);
                    end
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        while (pending_words.size() != 0 || item_valid || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic directed_words();
        plan_word(0, 0);
        plan_word(NODES - 1, VALUES - 1);
        plan_word('hAAA, 'h15555);
        plan_word('h555, 'h2AAAA);
        plan_word(0, VALUES);              // out of range, node is a member
        plan_word(1, 'h3FFFF);             // out of range, node is not a member
        plan_word(NODES - 1, 'h20000);
        plan_word(2, 1);
        plan_word(3, BUCKET_WIDTH);
        plan_word(4, BUCKET_WIDTH - 1);
        plan_word(0, 0);                   // leave: weight 0 absent again
        plan_word(2, 7);                   // leave with a weight already at zero
        plan_word(3, 1);                   // leave with another node's weight
        plan_word(5, 0);
        plan_word(6, 1);
        plan_word(7, 2);
        plan_word(8, 3);
        plan_word(9, VALUES - 1);
        plan_word(NODES - 1, VALUES - 1);
        plan_word(9, VALUES - 1);
    endtask

    task automatic random_words(int unsigned want);
        int unsigned made;
        int unsigned roll;
        int unsigned pick;
        int unsigned ahead;
        int unsigned node;
        int unsigned weight;
        made = 0;
        member_pool.delete();
        for (int unsigned n = 0; n < NODES; n++)
        begin
            if (planned_member[n])
                member_pool = {member_pool, n};
        end
        while (made < want)
        begin
            roll = $urandom_range(99);
            if (roll < 7)
            begin
                plan_word($urandom_range(NODES - 1), $urandom_range(2 ** WEIGHT_W - 1, VALUES));
            end
            else if (roll < 35 && member_pool.size() != 0)
            begin
                pick = $urandom_range(member_pool.size() - 1);
                node = member_pool[pick];
                member_pool.delete(pick);
                weight = (roll < 30) ? planned_weight[node] : $urandom_range(VALUES - 1);
                plan_word(node, weight);
                made++;
            end
            else
            begin
                do
                    node = $urandom_range(NODES - 1);
                while (planned_member[node]);
                if (roll < 42)
                begin
                    weight = $urandom_range(VALUES - 1);
                end
                else
                begin
                    // grow a dense run of weights so buckets fill up
                    ahead = ($urandom_range(3) == 0) ? $urandom_range(5) : 0;
                    weight = (frontier + ahead < VALUES) ? frontier + ahead : frontier;
                    frontier = (frontier + 1) % VALUES;
                end
                member_pool = {member_pool, node};
                plan_word(node, weight);
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(0, 0);
        directed_words();
        drain();

        set_idling(0, 0);
        random_words(RANDOM_PER_MIX);
        drain();
        set_idling(66, 0);
        random_words(RANDOM_PER_MIX);
        drain();
        set_idling(0, 66);
        random_words(RANDOM_PER_MIX);
        drain();
        set_idling(12, 12);
        random_words(RANDOM_PER_MIX);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
